// ----- hw/rtl/bfea_pkg.sv -----
// Shared types and constants for the best-fit extent allocator.
package bfea_pkg;

    localparam int MAX_EXTENTS = 16;
    localparam int DISK_BLOCKS = 16384;
    localparam int BLOCK_W     = 14;
    localparam int SIZE_W      = 15;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    typedef enum logic [0:0] {
        OP_FREE  = 1'b0,
        OP_ALLOC = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [0:0]         opcode;
        logic [BLOCK_W-1:0] free_first;
        logic [BLOCK_W-1:0] free_last;
        logic [SIZE_W-1:0]  request_size;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [BLOCK_W-1:0] alloc_start;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // capture request, rewind scan
        logic    step;       // advance scan index
        logic    scan_alloc; // evaluate current entry as best-fit candidate
        logic    grow;       // extend current entry to free_last
        logic    insert;     // open slot at scan index, write freed range
        logic    merge;      // fold entry at scan index into the one before
        logic    drop_best;  // remove best entry (exact fit)
        logic    shrink;     // trim best entry from the front
        logic    set_status;
        status_t status_val;
        logic    grant;      // publish best entry start as alloc_start
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic in_range;
        logic below;
        logic adjacent;
        logic touch;
        logic full;
        logic range_bad;
        logic found;
        logic exact;
    } sts_t;

endpackage

// ----- hw/rtl/best_fit_extent_allocator_core.sv -----
// Top level: best-fit free-extent allocator core.
// Free scans entries up to its insert or merge point; allocate scans every entry,
//   then shrinks or removes the best fit, if one was found.
// Throughput: one transaction at a time; the one-entry-per-cycle table scan sets the rate.
// The result sits on rsp for one cycle with done high; the receiver cannot stall.
// Reset (rst_n, async, active low) empties the table; no clearing pass is needed.
module best_fit_extent_allocator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  bfea_pkg::req_t req,
    output logic           done,
    output bfea_pkg::rsp_t rsp
);

    bfea_pkg::cmd_t cmd;
    bfea_pkg::sts_t sts;

    // Sequencer: scan, then insert/grow/merge or shrink/remove
    bfea_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Extent table held in flops; one entry examined per scan cycle
    bfea_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

    // A transaction accepted while idle makes the core busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

    // The done strobe lasts one cycle and returns the core to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> (!done && !busy))
    else $error("done strobe not a single cycle");

    // Failed transactions never report a start block
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != bfea_pkg::ST_DONE) |-> (rsp.alloc_start == '0))
    else $error("alloc_start set on failed transaction");

    // Status code 3 is never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status != bfea_pkg::ST_UNUSED))
    else $error("undefined status returned");

endmodule

// ----- hw/rtl/bfea_dp.sv -----
// Datapath: extent table, scan index, best-fit tracking and result register.
module bfea_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  bfea_pkg::req_t req,
    input  bfea_pkg::cmd_t cmd,
    output bfea_pkg::sts_t sts,
    output bfea_pkg::rsp_t rsp
);

    logic [bfea_pkg::BLOCK_W-1:0] first_reg [bfea_pkg::MAX_EXTENTS];
    logic [bfea_pkg::BLOCK_W-1:0] last_reg  [bfea_pkg::MAX_EXTENTS];
    logic [bfea_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [bfea_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [bfea_pkg::IDX_W-1:0]   node_reg;
    logic [bfea_pkg::IDX_W-1:0]   best_idx_reg;
    logic signed [bfea_pkg::BLOCK_W+1:0] best_size_reg;
    logic [bfea_pkg::BLOCK_W-1:0] best_first_reg;
    logic                         found_reg;
    bfea_pkg::req_t               req_reg;
    bfea_pkg::rsp_t               rsp_reg;

    logic [bfea_pkg::IDX_W-1:0]   idx_a;
    logic [bfea_pkg::BLOCK_W-1:0] rd_first, rd_last;
    logic signed [bfea_pkg::BLOCK_W+1:0] cur_size;
    logic signed [bfea_pkg::SIZE_W+1:0]  want;
    logic                         fits, better, take;
    logic [bfea_pkg::IDX_W-1:0]   drop_at;
    logic                         drop_en;

    assign idx_a    = idx_reg[bfea_pkg::IDX_W-1:0];
    assign rd_first = first_reg[idx_a];
    assign rd_last  = last_reg[idx_a];

    assign cur_size = $signed({2'b00, rd_last}) - $signed({2'b00, rd_first})
                      + $signed((bfea_pkg::BLOCK_W+2)'(1));
    assign want     = $signed({2'b00, req_reg.request_size});
    assign fits     = want <= (bfea_pkg::SIZE_W+2)'(cur_size);
    assign better   = !found_reg || (cur_size < best_size_reg);
    assign take     = cmd.scan_alloc && sts.in_range && fits && better;

    assign drop_en  = cmd.merge || cmd.drop_best;
    assign drop_at  = cmd.merge ? idx_a : best_idx_reg;

    always_comb
    begin
        sts.is_alloc  = (req_reg.opcode == bfea_pkg::OP_ALLOC);
        sts.in_range  = (idx_reg < cnt_reg);
        sts.below     = (rd_last < req_reg.free_first);
        sts.adjacent  = (req_reg.free_first != '0)
                        && (rd_last == req_reg.free_first - bfea_pkg::BLOCK_W'(1));
        sts.touch     = ({1'b0, req_reg.free_last} + (bfea_pkg::BLOCK_W+1)'(1))
                        == {1'b0, rd_first};
        sts.full      = (cnt_reg == bfea_pkg::CNT_W'(bfea_pkg::MAX_EXTENTS));
        sts.range_bad = (int'(req_reg.free_first) >= bfea_pkg::DISK_BLOCKS)
                        || (int'(req_reg.free_last) >= bfea_pkg::DISK_BLOCKS);
        sts.found     = found_reg;
        sts.exact     = (best_size_reg == (bfea_pkg::BLOCK_W+2)'(want));
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
            idx_next = '0;
        else if (cmd.step || cmd.grow || cmd.insert)
            idx_next = idx_reg + bfea_pkg::CNT_W'(1);
        cnt_next = cnt_reg;
        if (cmd.insert)
            cnt_next = cnt_reg + bfea_pkg::CNT_W'(1);
        else if (drop_en)
            cnt_next = cnt_reg - bfea_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            if (cmd.load)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
        end
    end

    // Table, tracking and result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg             <= req;
            rsp_reg.alloc_start <= '0;
        end
        if (cmd.grow || cmd.insert)
            node_reg <= idx_a;
        if (take)
        begin
            best_idx_reg   <= idx_a;
            best_size_reg  <= cur_size;
            best_first_reg <= rd_first;
        end
        if (cmd.set_status)
            rsp_reg.status <= cmd.status_val;
        if (cmd.grant)
            rsp_reg.alloc_start <= best_first_reg;

        for (int k = 0; k < bfea_pkg::MAX_EXTENTS; k++)
        begin
            if (cmd.insert)
            begin
                if (k > int'(idx_a))
                begin
                    first_reg[k] <= first_reg[k-1];
                    last_reg[k]  <= last_reg[k-1];
                end
                else if (k == int'(idx_a))
                begin
                    first_reg[k] <= req_reg.free_first;
                    last_reg[k]  <= req_reg.free_last;
                end
            end
            if (cmd.grow && k == int'(idx_a))
                last_reg[k] <= req_reg.free_last;
            if (drop_en && k >= int'(drop_at) && k < bfea_pkg::MAX_EXTENTS - 1)
            begin
                first_reg[k] <= first_reg[k+1];
                last_reg[k]  <= last_reg[k+1];
            end
            if (cmd.merge && k == int'(node_reg))
                last_reg[k] <= rd_last;
            if (cmd.shrink && k == int'(best_idx_reg))
                first_reg[k] <= best_first_reg
                                + req_reg.request_size[bfea_pkg::BLOCK_W-1:0];
        end
    end

    assign rsp = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= bfea_pkg::CNT_W'(bfea_pkg::MAX_EXTENTS))
    else $error("extent count beyond table depth");

endmodule

// ----- hw/rtl/bfea_ctrl.sv -----
// Controller: sequences free and allocate transactions over the datapath.
module bfea_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bfea_pkg::sts_t sts,
    output bfea_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_FSCAN = 7'b0000100,
        S_MERGE = 7'b0001000,
        S_ASCAN = 7'b0010000,
        S_AUPD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
                state_next = sts.is_alloc ? S_ASCAN : S_FSCAN;
            S_FSCAN:
            begin
                if (sts.range_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = bfea_pkg::ST_DONE;
                    state_next     = S_DONE;
                end
                else if (sts.in_range && sts.below)
                begin
                    if (sts.adjacent)
                    begin
                        cmd.grow   = 1'b1;
                        state_next = S_MERGE;
                    end
                    else
                        cmd.step = 1'b1;
                end
                else if (sts.full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = bfea_pkg::ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge      = sts.in_range && sts.touch;
                cmd.set_status = 1'b1;
                cmd.status_val = bfea_pkg::ST_DONE;
                state_next     = S_DONE;
            end
            S_ASCAN:
            begin
                if (sts.in_range)
                begin
                    cmd.scan_alloc = 1'b1;
                    cmd.step       = 1'b1;
                end
                else if (!sts.found)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = bfea_pkg::ST_NO_FIT;
                    state_next     = S_DONE;
                end
                else
                    state_next = S_AUPD;
            end
            S_AUPD:
            begin
                cmd.drop_best  = sts.exact;
                cmd.shrink     = !sts.exact;
                cmd.grant      = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status_val = bfea_pkg::ST_DONE;
                state_next     = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule
